// ----- rtl/core/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Shared types, codes and small helper functions for the Playfair digraph
// encryptor: channel payloads, controller commands and square arithmetic.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_KEY   = 2'd1;
  localparam logic [1:0] CMD_PLAIN = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // Letter codes and square geometry.
  localparam logic [4:0] CODE_I   = 5'd8;
  localparam logic [4:0] CODE_J   = 5'd9;
  localparam logic [4:0] CODE_X   = 5'd23;
  localparam int         LETTERS  = 26;
  localparam int         CELLS    = 25;
  localparam int         SIDE     = 5;
  localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
  localparam logic [4:0] CELL_COUNT  = 5'(CELLS);

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] command;
    logic [4:0] letter;
  } pfe_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [4:0] cipher_letter;
    logic       last_of_pair;
  } pfe_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clear;
    logic place_key;
    logic sweep_start;
    logic sweep_place;
    logic set_complete;
    logic set_pending;
    logic look_a;
    logic look_b;
    logic calc;
    logic sq_a;
    logic sq_b;
    logic load_first;
    logic load_second;
  } pfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       letter_ok;
    logic       complete;
    logic       pend_valid;
    logic       sweep_last;
    logic       out_free;
  } pfe_sts_t;

  // Row of a square position (0 to 24), found by comparison.
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Column of a square position: the position less five times its row.
  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    r    = pos_row(p);
    base = ({2'b00, r} << 2) + {2'b00, r};
    return 3'(p - base);
  endfunction

  // Row and column back to a square position.
  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  // Cyclic step along a row or a column.
  function automatic logic [2:0] step_wrap(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

// ----- rtl/core/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Playfair encryptor controller
// State machine that sequences key loading, square completion, table lookups
// and the two result letters of each pair.
// ----------------------------------------------------------------------------
module pfe_ctrl
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pfe_sts_t sts,
  output pfe_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_FILL   = 4'd2;
  localparam logic [3:0] ST_PAIR   = 4'd3;
  localparam logic [3:0] ST_LOOKA  = 4'd4;
  localparam logic [3:0] ST_LOOKB  = 4'd5;
  localparam logic [3:0] ST_CALC   = 4'd6;
  localparam logic [3:0] ST_SQA    = 4'd7;
  localparam logic [3:0] ST_EMA    = 4'd8;
  localparam logic [3:0] ST_SQB    = 4'd9;
  localparam logic [3:0] ST_EMB    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Only the idle state takes a new transaction.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.command)
          CMD_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
          CMD_KEY: begin
            cmd.place_key = sts.letter_ok && !sts.complete;
            state_nxt     = ST_IDLE;
          end
          CMD_PLAIN: begin
            if (!sts.letter_ok) begin
              state_nxt = ST_IDLE;
            end else if (!sts.complete) begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_FILL;
            end else begin
              state_nxt = ST_PAIR;
            end
          end
          CMD_END: begin
            state_nxt = sts.pend_valid ? ST_LOOKA : ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_FILL: begin
        cmd.sweep_place = 1'b1;
        if (sts.sweep_last) begin
          cmd.set_complete = 1'b1;
          state_nxt        = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (!sts.pend_valid) begin
          cmd.set_pending = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_LOOKA;
        end
      end
      ST_LOOKA: begin
        cmd.look_a = 1'b1;
        state_nxt  = ST_LOOKB;
      end
      ST_LOOKB: begin
        cmd.look_b = 1'b1;
        state_nxt  = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        cmd.sq_a  = 1'b1;
        state_nxt = ST_EMA;
      end
      ST_EMA: begin
        if (sts.out_free) begin
          cmd.load_first = 1'b1;
          state_nxt      = ST_SQB;
        end
      end
      ST_SQB: begin
        cmd.sq_b  = 1'b1;
        state_nxt = ST_EMB;
      end
      ST_EMB: begin
        if (sts.out_free) begin
          cmd.load_second = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/pfe_dp.sv -----
// ----------------------------------------------------------------------------
// Playfair encryptor datapath
// Holds the transaction, the square and its position table, the pending
// letter, the pair arithmetic and the result register.
// ----------------------------------------------------------------------------
module pfe_dp
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  pfe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pfe_out_t out_data,
  input  pfe_cmd_t cmd,
  output pfe_sts_t sts
);

  // Square contents and the position of each letter in it.
  logic [4:0] sq_mem  [CELLS];
  logic [4:0] pos_mem [LETTERS];

  logic [1:0]       cmd_r;
  logic [4:0]       letter_r;
  logic [LETTERS-1:0] used_r;
  logic [4:0]       kc_r;
  logic             complete_r;
  logic [4:0]       pend_letter_r;
  logic             pend_valid_r;
  logic [4:0]       sweep_r;
  logic [4:0]       pos_rd_r;
  logic [4:0]       pa_r;
  logic [4:0]       ia_r;
  logic [4:0]       ib_r;
  logic [4:0]       sq_rd_r;
  logic             out_valid_r;
  pfe_out_t         out_data_r;

  logic [4:0] folded;
  logic [4:0] b_letter;
  logic [4:0] place_c;
  logic       place_ok;
  logic       place_en;
  logic [4:0] pos_addr;
  logic [2:0] ra, ca, rb, cb;
  logic [2:0] ra_n, ca_n, rb_n, cb_n;

  // J is always folded onto I.
  assign folded = (in_data.letter == CODE_J) ? CODE_I : in_data.letter;

  // Second letter of the pair: X at end of message or for a doubled letter.
  assign b_letter = ((cmd_r == CMD_END) || (letter_r == pend_letter_r)) ? CODE_X : letter_r;

  // Placement of one letter, from a key transaction or the completion sweep.
  assign place_c  = cmd.sweep_place ? sweep_r : letter_r;
  assign place_ok = (place_c != CODE_J) && (place_c <= LAST_LETTER) &&
                    (kc_r < CELL_COUNT) && !used_r[place_c];
  assign place_en = (cmd.place_key || cmd.sweep_place) && place_ok;

  // Pair rules on the two looked-up positions.
  always_comb begin
    ra   = pos_row(pa_r);
    ca   = pos_col(pa_r);
    rb   = pos_row(pos_rd_r);
    cb   = pos_col(pos_rd_r);
    ra_n = ra;
    ca_n = ca;
    rb_n = rb;
    cb_n = cb;
    if (ra != rb && ca != cb) begin
      ca_n = cb;
      cb_n = ca;
    end else if (ra == rb && ca != cb) begin
      ca_n = step_wrap(ca);
      cb_n = step_wrap(cb);
    end else if (ra != rb && ca == cb) begin
      ra_n = step_wrap(ra);
      rb_n = step_wrap(rb);
    end
  end

  assign pos_addr = cmd.look_a ? pend_letter_r : b_letter;

  // Square and position table writes.
  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[kc_r]     <= place_c;
      pos_mem[place_c] <= kc_r;
    end
  end

  // Registered table reads.
  always_ff @(posedge clk) begin
    if (cmd.look_a || cmd.look_b) begin
      pos_rd_r <= pos_mem[pos_addr];
    end
    if (cmd.sq_a || cmd.sq_b) begin
      sq_rd_r <= sq_mem[cmd.sq_a ? ia_r : ib_r];
    end
  end

  // Transaction capture and pair arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r    <= in_data.command;
      letter_r <= folded;
    end
    if (cmd.look_b) begin
      pa_r <= pos_rd_r;
    end
    if (cmd.calc) begin
      ia_r <= cell_index(ra_n, ca_n);
      ib_r <= cell_index(rb_n, cb_n);
    end
    if (cmd.set_pending) begin
      pend_letter_r <= letter_r;
    end
    if (cmd.sweep_start) begin
      sweep_r <= '0;
    end else if (cmd.sweep_place) begin
      sweep_r <= sweep_r + 5'd1;
    end
  end

  // Square bookkeeping and pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      kc_r         <= '0;
      complete_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (cmd.clear) begin
      used_r       <= '0;
      kc_r         <= '0;
      complete_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (place_en) begin
        used_r[place_c] <= 1'b1;
        kc_r            <= kc_r + 5'd1;
      end
      if (cmd.set_complete) begin
        complete_r <= 1'b1;
      end
      if (cmd.set_pending) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.look_a) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_first || cmd.load_second) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first || cmd.load_second) begin
      out_data_r.cipher_letter <= sq_rd_r;
      out_data_r.last_of_pair  <= cmd.load_second;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status towards the controller.
  assign sts.command    = cmd_r;
  assign sts.letter_ok  = (letter_r <= LAST_LETTER);
  assign sts.complete   = complete_r;
  assign sts.pend_valid = pend_valid_r;
  assign sts.sweep_last = (sweep_r == LAST_LETTER);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ----- rtl/core/playfair_digraph_encrypt.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Builds a 5x5 key square from key letters and encrypts plaintext letters
// pair by pair, giving two cipher letters for each pair.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall  command, letter
//   out_      output     out_valid/out_stall cipher_letter, last_of_pair
//
// A clear, a key letter or an ignored letter passes only the decode state, and
// the first letter of a pair also the pair state. The letter that closes a pair,
// or an end of message with an open pair, goes on through two position lookups,
// the pair arithmetic and two square reads, as each lookup goes through one read
// port of the position table and then of the square. The first plaintext letter
// after the key also runs the sweep that completes the square.
// Reset is synchronous and active low; the tables need no clearing pass.
// A stall on the result side holds the controller before each letter load.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pfe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pfe_out_t out_data
);

  pfe_cmd_t cmd;
  pfe_sts_t sts;

  // Sequencer.
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, arithmetic and result register.
  pfe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef ASSERT_OFF
  // A lookup starts only on a complete square with an open pair.
  a_lookup_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.look_a |-> (sts.complete && sts.pend_valid))
    else $error("pair lookup started without a complete square or open pair");

  // A result letter is loaded only when the result register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_first || cmd.load_second) |-> sts.out_free)
    else $error("result register overwritten");

  // While the first letter of a pair waits, no new transaction is taken.
  a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_pair) |-> in_stall)
    else $error("input taken in the middle of a pair");

  // At most one table write or result load per cycle.
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.place_key, cmd.sweep_place, cmd.load_first, cmd.load_second}))
    else $error("conflicting datapath commands");
`endif

endmodule
